[rtl/assert_macros.svh]
// Assertion helpers for the hash block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ANH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ANH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/anh_pkg.sv]
package anh_pkg;

  localparam int unsigned NUM_EXT = 4;

  localparam logic [7:0] MAX_PART_CHARS = 8'd255;

  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // .nif .kf .dds .wav, lowercase
  localparam logic [7:0] EXT_PAT [NUM_EXT][4] = '{
    '{8'h2E, 8'h6E, 8'h69, 8'h66},
    '{8'h2E, 8'h6B, 8'h66, 8'h00},
    '{8'h2E, 8'h64, 8'h64, 8'h73},
    '{8'h2E, 8'h77, 8'h61, 8'h76}
  };
  localparam logic [2:0] EXT_LEN [NUM_EXT] = '{3'd4, 3'd3, 3'd4, 3'd4};

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_extension;
    logic       end_of_key;
  } anh_item_t;

  typedef struct packed {
    logic [31:0] hash_low;
    logic [31:0] hash_high;
    logic        too_long;
  } anh_result_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } anh_ext_hit_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
  endfunction

  function automatic logic [7:0] hash_char(input logic [7:0] lc);
    return (lc == CHAR_SLASH) ? CHAR_BSLASH : lc;
  endfunction

  // h * 0x1003F + c as shift-add
  function automatic logic [31:0] mac(input logic [31:0] h, input logic [7:0] c);
    return (h << 16) + (h << 6) - h + {24'd0, c};
  endfunction

endpackage

[rtl/archive_name_hash.sv]
// Streaming archive name hash.
// Input channel (in_valid / in_stall): one character per transaction, name
// characters first (in_is_extension = 0), then the extension including its
// dot (in_is_extension = 1); in_end_of_key marks the last character of a key.
// Result channel (out_valid / out_stall): one transaction per key, carrying
// the 64-bit hash as out_hash_low / out_hash_high, or out_too_long = 1 with a
// zero hash when the name or extension ran past MAX_PART_CHARS (255) chars.
// Throughput: one character per cycle while in_stall is low. Each character
// sits in the input register, where the hash update (a shift-add multiply
// by 0x1003F into a 32-bit accumulator) is done; the result is registered,
// so out_valid rises when the last character moves on to the result register.
// A stalled receiver holds the result register; the next key keeps
// streaming in until its own last character needs the result register.
// Reset (rst_n low, synchronous) empties both registers and clears the key
// state; the block accepts characters in the first cycle after reset.
`include "assert_macros.svh"

module archive_name_hash #(
  parameter logic [7:0] MAX_PART_CHARS = anh_pkg::MAX_PART_CHARS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_is_extension,
  input  logic        in_end_of_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_low,
  output logic [31:0] out_hash_high,
  output logic        out_too_long
);
  import anh_pkg::*;

  logic        s1_valid_r;
  anh_item_t   s1_item_r;
  logic        out_valid_r;
  anh_result_t out_res_r;
  anh_result_t res;
  logic        out_free, s1_go, in_acc;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_item_r.end_of_key || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  anh_core #(
    .MAX_PART_CHARS (MAX_PART_CHARS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_go),
    .item  (s1_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= '{char_code: in_char_code, is_extension: in_is_extension,
                     end_of_key: in_end_of_key};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_item_r.end_of_key) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item_r.end_of_key) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hash_low  = out_res_r.hash_low;
  assign out_hash_high = out_res_r.hash_high;
  assign out_too_long  = out_res_r.too_long;

  `ANH_ASSERT_IMP(a_stall_needs_item, in_stall, s1_valid_r, "stall with empty input register")
  `ANH_ASSERT_IMP(a_too_long_zero, out_valid_r && out_res_r.too_long,
                  out_res_r.hash_low == 32'd0 && out_res_r.hash_high == 32'd0,
                  "overlong key with nonzero hash")
  `ANH_ASSERT_NXT(a_result_held, out_valid_r && out_stall, out_valid_r,
                  "stalled result dropped")
  `ANH_ASSERT_NXT(a_last_char_held, s1_valid_r && s1_item_r.end_of_key && !out_free,
                  s1_valid_r && s1_item_r.end_of_key, "last character lost while blocked")

endmodule

[rtl/anh_ext_match.sv]
module anh_ext_match (
  input  logic [7:0]            lc,
  input  logic [7:0]            pos,
  input  logic [3:0]            flags_cur,
  output logic [3:0]            flags_upd,
  input  logic [7:0]            fin_count,
  input  logic [3:0]            fin_flags,
  output anh_pkg::anh_ext_hit_t hit
);
  import anh_pkg::*;

  always_comb begin
    for (int k = 0; k < NUM_EXT; k++) begin
      flags_upd[k] = flags_cur[k] & ~((pos >= {5'd0, EXT_LEN[k]}) ||
                                      (EXT_PAT[k][pos[1:0]] != lc));
    end
  end

  // lowest matching pattern wins
  always_comb begin
    hit = '0;
    for (int k = NUM_EXT - 1; k >= 0; k--) begin
      if (fin_count != 8'd0 && fin_flags[k] && fin_count == {5'd0, EXT_LEN[k]}) begin
        hit.hit = 1'b1;
        hit.idx = 2'(k);
      end
    end
  end

endmodule

[rtl/anh_core.sv]
module anh_core #(
  parameter logic [7:0] MAX_PART_CHARS = anh_pkg::MAX_PART_CHARS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  anh_pkg::anh_item_t   item,
  output anh_pkg::anh_result_t res
);
  import anh_pkg::*;

  logic [7:0]  name_count_r, name_count_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  recent0_r, recent0_nxt;
  logic [7:0]  recent1_r, recent1_nxt;
  logic [31:0] inner_r, inner_nxt;
  logic [31:0] ext_sum_r, ext_sum_nxt;
  logic [7:0]  ext_count_r, ext_count_nxt;
  logic [3:0]  ext_flags_r, ext_flags_nxt;
  logic        ext_phase_r, ext_phase_nxt;
  logic        ovf_r, ovf_nxt;

  logic [7:0]   lc;
  logic [3:0]   flags_upd;
  anh_ext_hit_t hit;
  logic [7:0]   b0, b1, b3, iv;

  assign lc = fold(item.char_code);

  anh_ext_match u_ext (
    .lc        (lc),
    .pos       (ext_count_r),
    .flags_cur (ext_flags_r),
    .flags_upd (flags_upd),
    .fin_count (ext_count_nxt),
    .fin_flags (ext_flags_nxt),
    .hit       (hit)
  );

  always_comb begin
    name_count_nxt = name_count_r;
    first_nxt      = first_r;
    recent0_nxt    = recent0_r;
    recent1_nxt    = recent1_r;
    inner_nxt      = inner_r;
    ext_sum_nxt    = ext_sum_r;
    ext_count_nxt  = ext_count_r;
    ext_flags_nxt  = ext_flags_r;
    ext_phase_nxt  = ext_phase_r;
    ovf_nxt        = ovf_r;
    if (item.is_extension) begin
      ext_phase_nxt = 1'b1;
      if (ext_count_r >= MAX_PART_CHARS) begin
        ovf_nxt = 1'b1;
      end else begin
        ext_sum_nxt   = mac(ext_sum_r, hash_char(lc));
        ext_flags_nxt = flags_upd;
        ext_count_nxt = ext_count_r + 8'd1;
      end
    end else if (!ext_phase_r) begin
      if (name_count_r >= MAX_PART_CHARS) begin
        ovf_nxt = 1'b1;
      end else begin
        if (name_count_r == 8'd0) begin
          first_nxt = lc;
        end
        if (name_count_r >= 8'd3) begin
          inner_nxt = mac(inner_r, hash_char(recent1_r));
        end
        recent1_nxt    = recent0_r;
        recent0_nxt    = lc;
        name_count_nxt = name_count_r + 8'd1;
      end
    end
  end

  always_comb begin
    b0 = recent0_nxt;
    b1 = (name_count_nxt > 8'd2) ? recent1_nxt : 8'd0;
    b3 = first_nxt;
    iv = {6'd0, hit.idx} + 8'd1;
    if (hit.hit) begin
      b3 = b3 + ((iv & 8'hFC) << 5);
      b0 = b0 + ((iv & 8'hFE) << 6);
      b1 = b1 + (iv << 7);
    end
    if (ovf_nxt) begin
      res = '{hash_low: 32'd0, hash_high: 32'd0, too_long: 1'b1};
    end else begin
      res.hash_low  = {b3, name_count_nxt, b1, b0};
      res.hash_high = inner_nxt + ext_sum_nxt;
      res.too_long  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.end_of_key)) begin
      name_count_r <= '0;
      first_r      <= '0;
      recent0_r    <= '0;
      recent1_r    <= '0;
      inner_r      <= '0;
      ext_sum_r    <= '0;
      ext_count_r  <= '0;
      ext_flags_r  <= '1;
      ext_phase_r  <= 1'b0;
      ovf_r        <= 1'b0;
    end else if (step) begin
      name_count_r <= name_count_nxt;
      first_r      <= first_nxt;
      recent0_r    <= recent0_nxt;
      recent1_r    <= recent1_nxt;
      inner_r      <= inner_nxt;
      ext_sum_r    <= ext_sum_nxt;
      ext_count_r  <= ext_count_nxt;
      ext_flags_r  <= ext_flags_nxt;
      ext_phase_r  <= ext_phase_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import anh_pkg::*;

  localparam int          PART_LIMIT     = 255;
  localparam logic [31:0] HASH_MUL       = 32'h0001_003F;
  localparam int          RANDOM_CHARS   = 450;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          TAIL_CYCLES    = 10;

  // recognized suffixes, lowercase, first char in the top byte
  localparam logic [3:0][31:0] SUFFIX_WORD = {
    32'h2E77_6176, 32'h2E64_6473, 32'h2E6B_6600, 32'h2E6E_6966
  };
  localparam logic [3:0][2:0] SUFFIX_LEN = {3'd4, 3'd4, 3'd3, 3'd4};

  typedef struct packed {
    anh_item_t ch;
    logic      drain_first;
  } queued_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = 8'd0;
  logic        in_is_extension = 1'b0;
  logic        in_end_of_key = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_hash_low;
  logic [31:0] out_hash_high;
  logic        out_too_long;

  archive_name_hash u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_is_extension(in_is_extension),
    .in_end_of_key  (in_end_of_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_low   (out_hash_low),
    .out_hash_high  (out_hash_high),
    .out_too_long   (out_too_long)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  queued_char_t char_queue[$];
  anh_result_t  expected_hashes[$];
  logic [7:0]   name_buf[$];
  logic [7:0]   ext_buf[$];
  anh_item_t    cur_char;
  int           total_chars;
  int           chars_accepted;
  int           hashes_seen;
  int           mismatches;
  int           send_gap;
  int           stall_left;
  int           hold_left;
  bit           hold_done;
  int           idle_cycles;

  // running key state
  int unsigned  key_name_len;
  int unsigned  key_ext_len;
  logic [7:0]   key_first;
  logic [7:0]   key_last;
  logic [7:0]   key_prev;
  logic [31:0]  key_inner_hash;
  logic [31:0]  key_ext_hash;
  logic [3:0]   key_suffix_ok;
  logic         key_in_ext;
  logic         key_overflow;

  function automatic logic [7:0] lower_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] path_char(input logic [7:0] lc);
    return (lc == "/") ? "\\" : lc;
  endfunction

  task automatic clear_key();
    key_name_len   = 0;
    key_ext_len    = 0;
    key_first      = 8'd0;
    key_last       = 8'd0;
    key_prev       = 8'd0;
    key_inner_hash = 32'd0;
    key_ext_hash   = 32'd0;
    key_suffix_ok  = 4'hF;
    key_in_ext     = 1'b0;
    key_overflow   = 1'b0;
  endtask

  task automatic hash_step(input anh_item_t it);
    logic [7:0]  lc;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b3;
    logic [7:0]  code;
    bit          found;
    anh_result_t r;
    lc = lower_char(it.char_code);
    if (it.is_extension) begin
      key_in_ext = 1'b1;
      if (key_ext_len >= PART_LIMIT) begin
        key_overflow = 1'b1;
      end else begin
        key_ext_hash = key_ext_hash * HASH_MUL + {24'd0, path_char(lc)};
        for (int k = 0; k < 4; k++) begin
          if (key_ext_len >= SUFFIX_LEN[k] ||
              SUFFIX_WORD[k][31 - 8 * (key_ext_len % 4) -: 8] != lc)
            key_suffix_ok[k] = 1'b0;
        end
        key_ext_len++;
      end
    end else if (!key_in_ext) begin
      if (key_name_len >= PART_LIMIT) begin
        key_overflow = 1'b1;
      end else begin
        if (key_name_len == 0) key_first = lc;
        if (key_name_len >= 3)
          key_inner_hash = key_inner_hash * HASH_MUL + {24'd0, path_char(key_prev)};
        key_prev = key_last;
        key_last = lc;
        key_name_len++;
      end
    end
    if (it.end_of_key) begin
      b0 = key_last;
      b1 = (key_name_len > 2) ? key_prev : 8'd0;
      b3 = key_first;
      found = 1'b0;
      if (key_ext_len > 0) begin
        for (int k = 0; k < 4; k++) begin
          if (!found && key_suffix_ok[k] && key_ext_len == SUFFIX_LEN[k]) begin
            code  = 8'(k + 1);
            b3    = b3 + ((code & 8'hFC) << 5);
            b0    = b0 + ((code & 8'hFE) << 6);
            b1    = b1 + (code << 7);
            found = 1'b1;
          end
        end
      end
      if (key_overflow) begin
        r.hash_low  = 32'd0;
        r.hash_high = 32'd0;
        r.too_long  = 1'b1;
      end else begin
        r.hash_low  = {b3, key_name_len[7:0], b1, b0};
        r.hash_high = key_inner_hash + key_ext_hash;
        r.too_long  = 1'b0;
      end
      expected_hashes.push_back(r);
      clear_key();
    end
  endtask

  function automatic logic [7:0] rnd_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom_range(97, 122));
      3, 4:    return 8'($urandom_range(65, 90));
      5:       return "/";
      6:       return "\\";
      7:       return ".";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] mixed_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
    return c;
  endfunction

  // stray: a name char dropped in after the extension has started
  task automatic add_key(input bit drain, input bit stray);
    anh_item_t    key[$];
    anh_item_t    it;
    queued_char_t q;
    int           pos;
    foreach (name_buf[i]) begin
      it = '{name_buf[i], 1'b0, 1'b0};
      key.push_back(it);
    end
    foreach (ext_buf[i]) begin
      it = '{ext_buf[i], 1'b1, 1'b0};
      key.push_back(it);
    end
    if (stray && ext_buf.size() != 0) begin
      pos = $urandom_range(name_buf.size() + 1, key.size());
      it  = '{rnd_char(), 1'b0, 1'b0};
      key.insert(pos, it);
    end
    key[key.size() - 1].end_of_key = 1'b1;
    foreach (key[i]) begin
      q.ch          = key[i];
      q.drain_first = drain && (i == 0);
      char_queue.push_back(q);
    end
    name_buf.delete();
    ext_buf.delete();
  endtask

  task automatic push_suffix(input int k);
    for (int p = 0; p < SUFFIX_LEN[k]; p++)
      ext_buf.push_back(mixed_case(SUFFIX_WORD[k][31 - 8 * p -: 8]));
  endtask

  function automatic bit calm_now();
    return (chars_accepted + 100 > total_chars) || ((chars_accepted / 150) % 3 == 2);
  endfunction

  // driver
  always @(posedge clk) begin
    queued_char_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        hash_step(cur_char);
        chars_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (char_queue.size() != 0 &&
                     !(char_queue[0].drain_first && expected_hashes.size() != 0)) begin
          nxt             = char_queue.pop_front();
          cur_char        = nxt.ch;
          in_char_code    <= nxt.ch.char_code;
          in_is_extension <= nxt.ch.is_extension;
          in_end_of_key   <= nxt.ch.end_of_key;
          in_valid        <= 1'b1;
          if (!calm_now() && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    anh_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        hashes_seen++;
        if (expected_hashes.size() == 0) begin
          $display("%0t unexpected transaction: low %h high %h too_long %b",
                   $time, out_hash_low, out_hash_high, out_too_long);
          mismatches++;
        end else begin
          want = expected_hashes.pop_front();
          if (out_hash_low !== want.hash_low) begin
            $display("%0t hash_low exp %h got %h", $time, want.hash_low, out_hash_low);
            mismatches++;
          end
          if (out_hash_high !== want.hash_high) begin
            $display("%0t hash_high exp %h got %h", $time, want.hash_high, out_hash_high);
            mismatches++;
          end
          if (out_too_long !== want.too_long) begin
            $display("%0t too_long exp %b got %b", $time, want.too_long, out_too_long);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && hashes_seen >= 15) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!calm_now() && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      out_stall <= (hold_left > 0) || (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int keys;
    int rand_chars;
    int before_size;
    int kind;
    int k;
    clear_key();

    name_buf.push_back("A");
    add_key(1'b0, 1'b0);
    name_buf.push_back("a");
    name_buf.push_back("b");
    add_key(1'b0, 1'b0);
    name_buf.push_back(8'h00);
    name_buf.push_back("/");
    name_buf.push_back("Q");
    name_buf.push_back(8'hFF);
    add_key(1'b0, 1'b0);
    ext_buf.push_back(".");
    ext_buf.push_back("N");
    ext_buf.push_back("I");
    ext_buf.push_back("F");
    add_key(1'b0, 1'b0);
    name_buf.push_back("x");
    ext_buf.push_back(".");
    ext_buf.push_back("k");
    ext_buf.push_back("f");
    add_key(1'b0, 1'b0);
    name_buf.push_back("y");
    name_buf.push_back("/");
    ext_buf.push_back(".");
    ext_buf.push_back("D");
    ext_buf.push_back("d");
    ext_buf.push_back("S");
    add_key(1'b0, 1'b0);
    name_buf.push_back("z");
    ext_buf.push_back(".");
    ext_buf.push_back("W");
    ext_buf.push_back("A");
    ext_buf.push_back("V");
    add_key(1'b0, 1'b1);
    ext_buf.push_back(".");
    add_key(1'b0, 1'b0);

    keys = 0;
    rand_chars = 0;
    while (rand_chars < RANDOM_CHARS) begin
      keys++;
      if (keys == 10) begin
        repeat (PART_LIMIT) name_buf.push_back(rnd_char());
        push_suffix(1);
        add_key(1'b0, 1'b0);
      end else if (keys == 20) begin
        repeat (PART_LIMIT + 1) name_buf.push_back(rnd_char());
        push_suffix($urandom_range(0, 3));
        add_key(1'b0, 1'b0);
      end else if (keys == 30) begin
        repeat (3) name_buf.push_back(rnd_char());
        repeat (PART_LIMIT + 1) ext_buf.push_back(rnd_char());
        add_key(1'b0, 1'b0);
      end else begin
        before_size = char_queue.size();
        repeat ($urandom_range(0, 10)) name_buf.push_back(rnd_char());
        kind = $urandom_range(0, 5);
        case (kind)
          2: push_suffix($urandom_range(0, 3));
          3: begin
            k = $urandom_range(0, 3);
            push_suffix(k);
            if ($urandom_range(0, 1) == 1) void'(ext_buf.pop_back());
            else ext_buf.push_back(rnd_char());
          end
          4: begin
            ext_buf.push_back(".");
            repeat ($urandom_range(0, 5)) ext_buf.push_back(rnd_char());
          end
          5: repeat ($urandom_range(1, 4)) ext_buf.push_back(rnd_char());
          default: ;
        endcase
        if (name_buf.size() == 0 && ext_buf.size() == 0) name_buf.push_back(rnd_char());
        add_key(keys == 5 || $urandom_range(0, 24) == 0, $urandom_range(0, 9) == 0);
        rand_chars += char_queue.size() - before_size;
      end
    end
    total_chars = char_queue.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (chars_accepted < total_chars || expected_hashes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_hashes.size() != 0) begin
      $display("%0t %0d expected hashes never arrived", $time, expected_hashes.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
